// ===== hw/rtl/minmax_linear_quantizer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// minmax linear quantizer assertion macros
// clocked property macros used by the quantizer top level
// ----------------------------------------------------------------------------
`ifndef MINMAX_LINEAR_QUANTIZER_UNIT_ASSERT_SVH
`define MINMAX_LINEAR_QUANTIZER_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define MLQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mlq same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define MLQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mlq next-cycle check failed");

`endif

// ===== hw/rtl/mlq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlq_pkg
// types, codes and widths shared by the min/max linear quantizer
// ----------------------------------------------------------------------------
package mlq_pkg;

   localparam int SAMPLE_W   = 32;
   localparam int LEVEL_W    = 17;
   localparam int INDEX_W    = 16;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int PROD_W     = 48;
   localparam int DIV1_STEPS = 16;
   localparam int DIV2_STEPS = 32;
   localparam int STEP_W     = 6;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 56;

   localparam logic [LEVEL_W-1:0] LEVELS_RESET = 17'd256;
   localparam logic [LEVEL_W-1:0] LEVELS_MIN   = 17'd2;
   localparam logic [LEVEL_W-1:0] LEVELS_MAX   = 17'h10000;

   localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MEASURE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUANTIZE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FEW      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_STATS = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_CLASS,
      ST_MUL1,
      ST_DIV1,
      ST_ROUND,
      ST_MUL2,
      ST_DIV2,
      ST_DONE
   } state_type;

   // clamp the level register into the supported range
   function automatic logic [LEVEL_W-1:0] eff_levels(input logic [LEVEL_W-1:0] raw);
      logic [LEVEL_W-1:0] res;
      if (raw < LEVELS_MIN) begin
         res = LEVELS_MIN;
      end else if (raw > LEVELS_MAX) begin
         res = LEVELS_MAX;
      end else begin
         res = raw;
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/minmax_linear_quantizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minmax_linear_quantizer_unit
// two-pass uniform quantizer: tracks min, max and count of measured samples,
// then maps a sample to the nearest of L evenly spaced levels
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake             payload
//   req      in   req_tvalid/tready     tuser: cmd, tdata: sample
//   rsp      out  rsp_tvalid/tready     tdata: level_index, level_value, status
//   csr      in   csr_valid/ready       csr_data: quantize_levels
//
// clear, measure and unused commands finish in the accept cycle
// a quantize word goes from accept to result through setup and one restoring
// divider, one quotient bit a cycle, that runs 16 steps for the index and 32 for
// the level offset, with rounding and the two multiply states; a sample
// at or below min or a zero range skips both divisions, one at or above max skips the index division
// reset (synchronous) clears the statistics and sets 256 levels
// a finished result waits in the output register; the next word is accepted
// while it waits, a new quantize result waits for that slot to free up
//
`include "minmax_linear_quantizer_unit_assert.svh"

module minmax_linear_quantizer_unit (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mlq_pkg::REQ_DATA_W-1:0]    req_tdata,   // [31:0] sample
   input  logic [mlq_pkg::CMD_W-1:0]         req_tuser,   // [1:0] cmd
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mlq_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [15:0] level_index,
                                                          // [47:16] level_value,
                                                          // [49:48] status, rest 0
   // level count register write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mlq_pkg::LEVEL_W-1:0]       csr_data
);
   import mlq_pkg::*;

   // control state
   state_type                    state_ff, state_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]           levels_ff, levels_in;
   logic [SAMPLE_W-1:0]          min_ff, min_in;
   logic [SAMPLE_W-1:0]          max_ff, max_in;
   logic [SAMPLE_W-1:0]          count_ff, count_in;
   logic [STEP_W-1:0]            step_ff, step_in;

   // datapath
   logic [SAMPLE_W-1:0]          sample_ff, sample_in;
   logic signed [SAMPLE_W:0]     diff_ff, diff_in;
   logic [SAMPLE_W-1:0]          range_ff, range_in;
   logic [INDEX_W-1:0]           idx_ff, idx_in;
   logic [PROD_W-1:0]            num_ff, num_in;      // dividend in, quotient out
   logic [SAMPLE_W-1:0]          rem_ff, rem_in;
   logic [SAMPLE_W-1:0]          den_ff, den_in;
   logic [RSP_DATA_W-1:0]        rsp_data_ff, rsp_data_in;

   logic                         req_fire;
   logic                         rsp_free;
   logic [LEVEL_W-1:0]           lvl;
   logic [LEVEL_W-1:0]           lvl_m1;

   // class of the sample against the measured range
   logic                         cls_zero;
   logic                         cls_top;

   // shared multiplier
   logic [SAMPLE_W-1:0]          mul_a;
   logic [LEVEL_W-1:0]           mul_b;
   logic [SAMPLE_W+LEVEL_W-1:0]  mul_p;

   // shared divider step
   logic [SAMPLE_W:0]            div_shift;
   logic [SAMPLE_W:0]            div_sub;
   logic                         div_geq;
   logic [SAMPLE_W-1:0]          div_rem;
   logic [PROD_W-1:0]            div_num;

   // rounding
   logic                         round_up;
   logic [LEVEL_W-1:0]           round_idx;

   // result fields
   logic [SAMPLE_W-1:0]          level_value;
   logic [STATUS_W-1:0]          status;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign lvl    = eff_levels(levels_ff);
   assign lvl_m1 = lvl - LEVEL_W'(1);

   assign cls_zero = (range_ff == '0) || (diff_ff <= 0);
   assign cls_top  = (diff_ff >= $signed({1'b0, range_ff}));

   // multiplier operands follow the sequencer state
   always_comb begin
      if (state_ff == ST_MUL2) begin
         mul_a = range_ff;
         mul_b = {1'b0, idx_ff};
      end else begin
         mul_a = diff_ff[SAMPLE_W-1:0];
         mul_b = lvl;
      end
   end
   assign mul_p = mul_a * mul_b;

   // restoring division, one quotient bit a step
   assign div_shift = {rem_ff, num_ff[PROD_W-1]};
   assign div_sub   = div_shift - {1'b0, den_ff};
   assign div_geq   = (div_shift >= {1'b0, den_ff});
   assign div_rem   = div_geq ? div_sub[SAMPLE_W-1:0] : div_shift[SAMPLE_W-1:0];
   assign div_num   = {num_ff[PROD_W-2:0], div_geq};

   // a tie rounds up, then clamp to the top level
   assign round_up  = ({rem_ff, 1'b0} >= {1'b0, range_ff});
   assign round_idx = ({1'b0, num_ff[INDEX_W-1:0]} + LEVEL_W'(round_up) > lvl_m1)
                      ? lvl_m1
                      : {1'b0, num_ff[INDEX_W-1:0]} + LEVEL_W'(round_up);

   assign level_value = min_ff + num_ff[SAMPLE_W-1:0];

   always_comb begin
      if (count_ff == '0) begin
         status = STATUS_NO_STATS;
      end else if (count_ff < {{(SAMPLE_W-LEVEL_W){1'b0}}, lvl}) begin
         status = STATUS_FEW;
      end else begin
         status = STATUS_OK;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser == CMD_QUANTIZE)) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            state_in = ST_CLASS;
         end
         ST_CLASS: begin
            if (cls_zero) begin
               state_in = ST_DONE;
            end else if (cls_top) begin
               state_in = ST_MUL2;
            end else begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            state_in = ST_DIV1;
         end
         ST_DIV1: begin
            if (step_ff == STEP_W'(1)) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            if (step_ff == STEP_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and statistics updates
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      levels_in    = levels_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      sample_in    = sample_ff;
      diff_in      = diff_ff;
      range_in     = range_ff;
      idx_in       = idx_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_valid && csr_ready) begin
         levels_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  CMD_CLEAR: begin
                     min_in   = '0;
                     max_in   = '0;
                     count_in = '0;
                  end
                  CMD_MEASURE: begin
                     if (count_ff == '0) begin
                        min_in = req_tdata;
                        max_in = req_tdata;
                     end else begin
                        if ($signed(req_tdata) < $signed(min_ff)) begin
                           min_in = req_tdata;
                        end
                        if ($signed(req_tdata) > $signed(max_ff)) begin
                           max_in = req_tdata;
                        end
                     end
                     if (count_ff != '1) begin
                        count_in = count_ff + SAMPLE_W'(1);
                     end
                  end
                  CMD_QUANTIZE: begin
                     sample_in = req_tdata;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIFF: begin
            diff_in  = $signed({sample_ff[SAMPLE_W-1], sample_ff})
                       - $signed({min_ff[SAMPLE_W-1], min_ff});
            range_in = max_ff - min_ff;
         end
         ST_CLASS: begin
            if (cls_zero) begin
               idx_in = '0;
               num_in = '0;
            end else if (cls_top) begin
               idx_in = lvl_m1[INDEX_W-1:0];
            end
         end
         ST_MUL1: begin
            // quotient stays below L, so the top 32 dividend bits start as remainder
            rem_in  = mul_p[PROD_W-1:DIV1_STEPS];
            num_in  = {mul_p[DIV1_STEPS-1:0], {(PROD_W-DIV1_STEPS){1'b0}}};
            den_in  = range_ff;
            step_in = STEP_W'(DIV1_STEPS);
         end
         ST_DIV1, ST_DIV2: begin
            rem_in  = div_rem;
            num_in  = div_num;
            step_in = step_ff - STEP_W'(1);
         end
         ST_ROUND: begin
            idx_in = round_idx[INDEX_W-1:0];
         end
         ST_MUL2: begin
            // offset stays below the range, so the top 16 bits start as remainder
            rem_in  = {{(SAMPLE_W-(PROD_W-DIV2_STEPS)){1'b0}}, mul_p[PROD_W-1:DIV2_STEPS]};
            num_in  = {mul_p[DIV2_STEPS-1:0], {(PROD_W-DIV2_STEPS){1'b0}}};
            den_in  = {{(SAMPLE_W-LEVEL_W){1'b0}}, lvl};
            step_in = STEP_W'(DIV2_STEPS);
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_DATA_W-STATUS_W-SAMPLE_W-INDEX_W){1'b0}},
                               status, level_value, idx_ff};
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         levels_ff    <= LEVELS_RESET;
         min_ff       <= '0;
         max_ff       <= '0;
         count_ff     <= '0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         levels_ff    <= levels_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      diff_ff     <= diff_in;
      range_ff    <= range_in;
      idx_ff      <= idx_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      rsp_data_ff <= rsp_data_in;
   end

   // checks
   `MLQ_ASSERT_NEXT(a_quant_starts, clock, reset, req_fire && (req_tuser == CMD_QUANTIZE), state_ff == ST_DIFF)
   `MLQ_ASSERT_SAME(a_div_steps_left, clock, reset, (state_ff == ST_DIV1) || (state_ff == ST_DIV2), step_ff != '0)
   `MLQ_ASSERT_SAME(a_min_le_max, clock, reset, count_ff != '0, $signed(min_ff) <= $signed(max_ff))
   `MLQ_ASSERT_SAME(a_empty_stats, clock, reset, count_ff == '0, (min_ff == '0) && (max_ff == '0))

endmodule
